@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the ordered list position engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define OLPE_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("olpe assertion failed");

`define OLPE_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("olpe assertion failed");

`else

`define OLPE_ASSERT(label, clk, rst_n, prop)

`define OLPE_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

@@ rtl/core/olpe_pkg.sv @@
// Package with widths, codes and the sequencer state type of the list engine.
`default_nettype none

package olpe_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int FUNC_W       = 3;
	localparam int POS_W        = 5;
	localparam int DATA_W       = 32;
	localparam int STAT_W       = 2;
	localparam int LEN_W        = 5;

	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LOCATE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FETCH,
		S_CAPTURE,
		S_MOVE,
		S_PLACE,
		S_SCAN,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/olpe_req_if.sv @@
// Request channel interface carrying one list operation per item.
`default_nettype none

interface olpe_req_if;
	import olpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [FUNC_W-1:0]        func;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] value;

	modport source (output valid, output func, output position, output value, input ready);
	modport sink (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/olpe_rsp_if.sv @@
// Response channel interface carrying one result item per request.
`default_nettype none

interface olpe_rsp_if;
	import olpe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [STAT_W-1:0]        status;
	logic signed [DATA_W-1:0] out_value;
	logic [POS_W-1:0]         found_position;
	logic [LEN_W-1:0]         length;

	modport source (output valid, output status, output out_value, output found_position,
		output length, input ready);
	modport sink (input valid, input status, input out_value, input found_position,
		input length, output ready);
endinterface

`default_nettype wire

@@ rtl/core/olpe_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module olpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/core/ordered_list_position_engine_top.sv @@
// Top level of the ordered list position engine with its shift and search sequencer.
// Each item is decoded after acceptance; a clear or a rejected request goes straight to finish,
// an insert at the end is placed directly, a get or a delete fetches and captures its element,
// other inserts and deletes shift entries past position p, a search scans to a hit or the end.
// The single RAM port pair moves or compares one entry a cycle; a waiting result adds stalls.
// Reset empties the list at once; the element RAM itself is never cleared.
`default_nettype none
`include "assert_macros.svh"

module ordered_list_position_engine_top #(
	parameter int CAPACITY = olpe_pkg::CAPACITY_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	olpe_req_if.sink    req,
	olpe_rsp_if.source  rsp
);
	import olpe_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

	state_t state_q;
	state_t state_d;

	logic [CW-1:0]     cnt_q;
	logic              rd_live_q;
	logic              pend_q;
	logic              rsp_vld_q;
	logic [FUNC_W-1:0] func_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     last_q;
	logic [AW-1:0]     pend_addr_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] outv_q;
	logic [POS_W-1:0]  found_q;
	logic [STAT_W-1:0] rsp_status_q;
	logic [DATA_W-1:0] rsp_value_q;
	logic [POS_W-1:0]  rsp_found_q;
	logic [LEN_W-1:0]  rsp_len_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	logic [CMPW-1:0] posx;
	logic [CMPW-1:0] cntx;
	logic            pos_zero;
	logic            ins_bad;
	logic            ins_full;
	logic            ins_app;
	logic            acc_bad;
	logic            hit;
	logic            ins_dir;
	logic            rsp_free;
	logic            req_acc;
	logic [AW-1:0]   pos_m1;
	logic [AW-1:0]   cnt_m1;

	olpe_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		posx     = CMPW'(pos_q);
		cntx     = CMPW'(cnt_q);
		pos_zero = (pos_q == '0);
		ins_bad  = pos_zero || (posx > cntx + CMPW'(1));
		ins_full = (cntx == CMPW'(CAPACITY));
		ins_app  = (posx == cntx + CMPW'(1));
		acc_bad  = pos_zero || (posx > cntx);
		hit      = (ram_rdata == val_q);
		ins_dir  = (func_q == FN_INSERT);
		rsp_free = !rsp_vld_q || rsp.ready;
		req_acc  = req.valid && req.ready;
		pos_m1   = AW'(pos_q - POS_W'(1));
		cnt_m1   = AW'(cnt_q - CW'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (func_q)
					FN_INSERT: begin
						if (ins_bad || ins_full) begin
							state_d = S_FINISH;
						end else if (ins_app) begin
							state_d = S_PLACE;
						end else begin
							state_d = S_MOVE;
						end
					end
					FN_DELETE, FN_GET: begin
						state_d = acc_bad ? S_FINISH : S_FETCH;
					end
					FN_LOCATE: begin
						state_d = (cnt_q == '0) ? S_FINISH : S_SCAN;
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_FETCH: state_d = S_CAPTURE;
			S_CAPTURE: begin
				if (func_q == FN_DELETE && idx_q != last_q) begin
					state_d = S_MOVE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_MOVE: begin
				if (!rd_live_q && !pend_q) begin
					state_d = ins_dir ? S_PLACE : S_FINISH;
				end
			end
			S_PLACE: state_d = S_FINISH;
			S_SCAN: begin
				if ((pend_q && hit) || (!rd_live_q && !pend_q)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		ram_raddr = idx_q;
		case (state_q)
			S_MOVE: begin
				ram_we    = pend_q;
				ram_waddr = pend_addr_q;
				ram_wdata = ram_rdata;
			end
			S_PLACE: begin
				ram_we    = 1'b1;
				ram_waddr = pos_m1;
				ram_wdata = val_q;
			end
			default: begin
				ram_we    = 1'b0;
				ram_waddr = pend_addr_q;
				ram_wdata = ram_rdata;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rd_live_q <= 1'b0;
			pend_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECODE: begin
					if (func_q == FN_CLEAR) begin
						cnt_q <= '0;
					end
					rd_live_q <= 1'b1;
					pend_q    <= 1'b0;
				end
				S_CAPTURE: begin
					if (func_q == FN_DELETE) begin
						cnt_q <= cnt_q - CW'(1);
					end
					rd_live_q <= 1'b1;
					pend_q    <= 1'b0;
				end
				S_MOVE, S_SCAN: begin
					pend_q <= rd_live_q;
					if (rd_live_q && idx_q == last_q) begin
						rd_live_q <= 1'b0;
					end
				end
				S_PLACE: begin
					cnt_q <= cnt_q + CW'(1);
				end
				default: begin
				end
			endcase
			if (state_q == S_FINISH && rsp_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_acc) begin
					func_q   <= req.func;
					pos_q    <= req.position;
					val_q    <= req.value;
					status_q <= STAT_OK;
					outv_q   <= '0;
					found_q  <= '0;
				end
			end
			S_DECODE: begin
				case (func_q)
					FN_INSERT: begin
						if (ins_bad) begin
							status_q <= STAT_BADPOS;
						end else if (ins_full) begin
							status_q <= STAT_FULL;
						end
						idx_q  <= cnt_m1;
						last_q <= pos_m1;
					end
					FN_DELETE, FN_GET: begin
						if (acc_bad) begin
							status_q <= STAT_BADPOS;
						end
						idx_q  <= pos_m1;
						last_q <= cnt_m1;
					end
					FN_LOCATE: begin
						status_q <= STAT_NOTFOUND;
						idx_q    <= '0;
						last_q   <= cnt_m1;
					end
					FN_CLEAR: begin
					end
					default: begin
						status_q <= STAT_BADPOS;
					end
				endcase
			end
			S_CAPTURE: begin
				outv_q <= ram_rdata;
				idx_q  <= idx_q + AW'(1);
			end
			S_MOVE: begin
				if (rd_live_q) begin
					pend_addr_q <= ins_dir ? idx_q + AW'(1) : idx_q - AW'(1);
					if (idx_q != last_q) begin
						idx_q <= ins_dir ? idx_q - AW'(1) : idx_q + AW'(1);
					end
				end
			end
			S_SCAN: begin
				if (rd_live_q) begin
					pend_addr_q <= idx_q;
					if (idx_q != last_q) begin
						idx_q <= idx_q + AW'(1);
					end
				end
				if (pend_q && hit) begin
					found_q  <= POS_W'(pend_addr_q) + POS_W'(1);
					status_q <= STAT_OK;
				end
			end
			S_FINISH: begin
				if (rsp_free) begin
					rsp_status_q <= status_q;
					rsp_value_q  <= outv_q;
					rsp_found_q  <= found_q;
					rsp_len_q    <= LEN_W'(cnt_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid          = rsp_vld_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.out_value      = rsp_value_q;
	assign rsp.found_position = rsp_found_q;
	assign rsp.length         = rsp_len_q;

	`OLPE_ASSERT(a_cnt_cap, clk, arst_n, CMPW'(cnt_q) <= CMPW'(CAPACITY))
	`OLPE_ASSERT(a_wr_bound, clk, arst_n, ram_we |-> (CMPW'(ram_waddr) <= CMPW'(cnt_q)))
	`OLPE_ASSERT(a_found_ok, clk, arst_n, (rsp_vld_q && rsp_found_q != '0) |-> (rsp_status_q == STAT_OK))
	`OLPE_ASSERT(a_cnt_step, clk, arst_n, (cnt_q != $past(cnt_q)) |-> (cnt_q == '0 || CMPW'(cnt_q) == CMPW'($past(cnt_q)) + CMPW'(1) || CMPW'(cnt_q) + CMPW'(1) == CMPW'($past(cnt_q))))
	`OLPE_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |-> (state_q == S_IDLE && !rsp_vld_q))

endmodule

`default_nettype wire
